// ===== design/mfpzs_pkg.sv =====
// Shared constants, types and register codes for the multi-feature pixel
// zero-suppression block.
// Stand-alone package; every other design file refers to it by scoped names.
package mfpzs_pkg;

    // Stream geometry.
    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS     = 4096;
    localparam int MAX_FEATURES = 4;
    localparam int LANES        = 4;
    localparam int LANE_LIMIT   = (MAX_FEATURES < LANES) ? MAX_FEATURES : LANES;

    // Field widths.
    localparam int ROW_W = 10;
    localparam int COL_W = 12;
    localparam int VAL_W = 16;

    // Configuration register widths.
    localparam int NUM_ROWS_W = 11;
    localparam int NUM_FEAT_W = 3;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(1024);
    localparam logic [NUM_FEAT_W-1:0] NUM_FEAT_RST = NUM_FEAT_W'(1);
    localparam logic [MASK_W-1:0]     MASK_RST     = MASK_W'(15);

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS     = 3'd0,
        CFG_NUM_FEATURES = 3'd1,
        CFG_INFILL_MODE  = 3'd2,
        CFG_REQUIRE_MASK = 3'd3,
        CFG_THRESHOLD_0  = 3'd4,
        CFG_THRESHOLD_1  = 3'd5,
        CFG_THRESHOLD_2  = 3'd6,
        CFG_THRESHOLD_3  = 3'd7
    } cfg_index_t;

    typedef logic [LANES-1:0][VAL_W-1:0] feat_vec_t;

    // One kept pixel as it waits in the queue.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        feat_vec_t        feat;
        logic [LANES-1:0] lane_en;
    } entry_t;

    // Write side of the queue.
    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    // Read side of the queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_rd_t;

    // One result as presented on the output ports.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        feat_vec_t        value;
    } result_t;

endpackage

// ===== design/mfpzs_front.sv =====
// Front end: configuration registers, row/column counters and the keep test.
// Depends on mfpzs_pkg; feeds mfpzs_fifo.
module mfpzs_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mfpzs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfpzs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  accept,
    input  logic                                  frame_start,
    input  mfpzs_pkg::feat_vec_t                  feat,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]    label,
    output mfpzs_pkg::q_wr_t                      q_wr
);

    logic [mfpzs_pkg::NUM_ROWS_W-1:0] num_rows_reg;
    logic [mfpzs_pkg::NUM_FEAT_W-1:0] num_feat_reg;
    logic                             infill_reg;
    logic [mfpzs_pkg::MASK_W-1:0]     mask_reg;
    logic [mfpzs_pkg::VAL_W-1:0]      thr_reg [mfpzs_pkg::LANES];

    logic [mfpzs_pkg::ROW_W-1:0]      row_reg;
    logic [mfpzs_pkg::ROW_W-1:0]      row_next;
    logic [mfpzs_pkg::COL_W-1:0]      col_reg;
    logic [mfpzs_pkg::COL_W-1:0]      col_next;

    logic [mfpzs_pkg::ROW_W-1:0]      base_row;
    logic [mfpzs_pkg::COL_W-1:0]      base_col;
    logic [mfpzs_pkg::NUM_ROWS_W-1:0] rows_use;
    logic [mfpzs_pkg::NUM_ROWS_W-1:0] row_inc;
    logic [mfpzs_pkg::NUM_FEAT_W-1:0] lanes_use;
    logic [mfpzs_pkg::LANES-1:0]      lane_en;
    logic [mfpzs_pkg::LANES-1:0]      lane_hit;
    logic                             keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= mfpzs_pkg::NUM_ROWS_RST;
            num_feat_reg <= mfpzs_pkg::NUM_FEAT_RST;
            infill_reg   <= 1'b0;
            mask_reg     <= mfpzs_pkg::MASK_RST;
            for (int i = 0; i < mfpzs_pkg::LANES; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (mfpzs_pkg::cfg_index_t'(cfg_index))
                mfpzs_pkg::CFG_NUM_ROWS:
                    num_rows_reg <= cfg_data[mfpzs_pkg::NUM_ROWS_W-1:0];
                mfpzs_pkg::CFG_NUM_FEATURES:
                    num_feat_reg <= cfg_data[mfpzs_pkg::NUM_FEAT_W-1:0];
                mfpzs_pkg::CFG_INFILL_MODE:
                    infill_reg   <= cfg_data[0];
                mfpzs_pkg::CFG_REQUIRE_MASK:
                    mask_reg     <= cfg_data[mfpzs_pkg::MASK_W-1:0];
                mfpzs_pkg::CFG_THRESHOLD_0:
                    thr_reg[0]   <= cfg_data[mfpzs_pkg::VAL_W-1:0];
                mfpzs_pkg::CFG_THRESHOLD_1:
                    thr_reg[1]   <= cfg_data[mfpzs_pkg::VAL_W-1:0];
                mfpzs_pkg::CFG_THRESHOLD_2:
                    thr_reg[2]   <= cfg_data[mfpzs_pkg::VAL_W-1:0];
                mfpzs_pkg::CFG_THRESHOLD_3:
                    thr_reg[3]   <= cfg_data[mfpzs_pkg::VAL_W-1:0];
            endcase
        end
    end

    // Clamp the register values to their legal ranges.
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_use = mfpzs_pkg::NUM_ROWS_W'(1);
        end
        else if (num_rows_reg > mfpzs_pkg::NUM_ROWS_W'(mfpzs_pkg::MAX_ROWS))
        begin
            rows_use = mfpzs_pkg::NUM_ROWS_W'(mfpzs_pkg::MAX_ROWS);
        end
        else
        begin
            rows_use = num_rows_reg;
        end

        if (num_feat_reg == '0)
        begin
            lanes_use = mfpzs_pkg::NUM_FEAT_W'(1);
        end
        else if (num_feat_reg > mfpzs_pkg::NUM_FEAT_W'(mfpzs_pkg::LANE_LIMIT))
        begin
            lanes_use = mfpzs_pkg::NUM_FEAT_W'(mfpzs_pkg::LANE_LIMIT);
        end
        else
        begin
            lanes_use = num_feat_reg;
        end
    end

    // Keep test and lane selection.
    always_comb
    begin
        for (int i = 0; i < mfpzs_pkg::LANES; i++)
        begin
            lane_hit[i] = $signed(feat[i]) >= $signed(thr_reg[i]);
        end

        if (infill_reg)
        begin
            lane_en = mfpzs_pkg::LANES'(1);
            keep    = lane_hit[0] || (label > 0);
        end
        else
        begin
            for (int i = 0; i < mfpzs_pkg::LANES; i++)
            begin
                lane_en[i] = mfpzs_pkg::NUM_FEAT_W'(i) < lanes_use;
            end
            keep = |(lane_en & mask_reg & lane_hit);
        end
    end

    // Counter advance. The start-of-frame flag clears both counters first.
    always_comb
    begin
        base_row = frame_start ? '0 : row_reg;
        base_col = frame_start ? '0 : col_reg;
        row_inc  = {1'b0, base_row} + mfpzs_pkg::NUM_ROWS_W'(1);

        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_inc >= rows_use)
            begin
                row_next = '0;
                if (base_col == mfpzs_pkg::COL_W'(mfpzs_pkg::MAX_COLS - 1))
                begin
                    col_next = base_col;
                end
                else
                begin
                    col_next = base_col + mfpzs_pkg::COL_W'(1);
                end
            end
            else
            begin
                row_next = row_inc[mfpzs_pkg::ROW_W-1:0];
                col_next = base_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_comb
    begin
        q_wr.push          = accept && keep;
        q_wr.entry.row     = base_row;
        q_wr.entry.col     = base_col;
        q_wr.entry.feat    = feat;
        q_wr.entry.lane_en = lane_en;
    end

    // The column counter holds once it reaches the last column.
    a_col_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_start
            && col_reg == mfpzs_pkg::COL_W'(mfpzs_pkg::MAX_COLS - 1))
        |=> (col_reg == mfpzs_pkg::COL_W'(mfpzs_pkg::MAX_COLS - 1)))
        else $error("column counter left saturation");

    // Without an accepted pixel the counters do not move.
    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(row_reg) && $stable(col_reg)))
        else $error("counters moved without an accepted pixel");

endmodule

// ===== design/mfpzs_fifo.sv =====
// Short register queue that decouples the keep test from the output stage.
// Depends on mfpzs_pkg; sits between mfpzs_front and mfpzs_back.
module mfpzs_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  mfpzs_pkg::q_wr_t  q_wr,
    input  logic              pop,
    output logic              full,
    output mfpzs_pkg::q_rd_t  q_rd
);

    mfpzs_pkg::entry_t            mem_reg [mfpzs_pkg::FIFO_DEPTH];
    logic [mfpzs_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [mfpzs_pkg::PTR_W-1:0]  wr_ptr_next;
    logic [mfpzs_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [mfpzs_pkg::PTR_W-1:0]  rd_ptr_next;
    logic [mfpzs_pkg::CNT_W-1:0]  cnt_reg;
    logic [mfpzs_pkg::CNT_W-1:0]  cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = cnt_reg == mfpzs_pkg::CNT_W'(mfpzs_pkg::FIFO_DEPTH);
    assign q_rd.valid = cnt_reg != '0;
    assign q_rd.entry = mem_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !full;
    assign do_pop     = pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mfpzs_pkg::PTR_W'(mfpzs_pkg::FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + mfpzs_pkg::PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mfpzs_pkg::PTR_W'(mfpzs_pkg::FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + mfpzs_pkg::PTR_W'(1);
        end
        cnt_next = cnt_reg + mfpzs_pkg::CNT_W'(do_push) - mfpzs_pkg::CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

    // The front must never push into a full queue; the entry would be lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.push && full))
        else $error("push into a full queue");

    // Fill level rises by one on a push that has no pop beside it.
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + mfpzs_pkg::CNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

// ===== design/mfpzs_back.sv =====
// Back end: output register that forms the result and zeroes unused lanes.
// Depends on mfpzs_pkg; drains mfpzs_fifo.
module mfpzs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mfpzs_pkg::q_rd_t  q_rd,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output mfpzs_pkg::result_t result
);

    logic               out_valid_reg;
    logic               out_valid_next;
    mfpzs_pkg::result_t result_reg;
    mfpzs_pkg::result_t result_next;

    assign pop = q_rd.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        result_next.row = q_rd.entry.row;
        result_next.col = q_rd.entry.col;
        for (int i = 0; i < mfpzs_pkg::LANES; i++)
        begin
            result_next.value[i] = q_rd.entry.lane_en[i] ? q_rd.entry.feat[i] : '0;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A new result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

endmodule

// ===== design/multi_feature_pixel_zero_suppress_top.sv =====
// Top level of the multi-feature pixel zero-suppression block.
// Depends on mfpzs_pkg and instantiates mfpzs_front, mfpzs_fifo and mfpzs_back.
//
// The block takes one pixel per clock in column-major order and passes on
// only the pixels that survive the keep test, tagged with their row and
// column. A pixel is accepted whenever in_valid is high and in_stall is low;
// in_stall rises only when the two-entry queue behind the keep test is full,
// so with the output side taking results the input never stalls and the
// sustained rate is one pixel per cycle. The keep test (one signed compare per
// lane) and the row/column counter update both finish in the accepting cycle,
// which is what sets that rate. A kept pixel is written into the queue at the
// edge that accepts it and moves into the output register once that register
// is free or being drained; out_valid then rises, and the result is taken at
// an edge with out_stall low. Unused feature lanes are reported as zero, and
// in infill mode only lane 0 is in use. The frame_start flag clears the
// counters before its own pixel is counted; the column counter holds at its
// last value instead of wrapping. Configuration is written through cfg_we,
// cfg_index and cfg_data, one register per edge, and should be changed only
// while no pixel is in flight.
module multi_feature_pixel_zero_suppress_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [mfpzs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfpzs_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                frame_start,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]  feature_0,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]  feature_1,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]  feature_2,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]  feature_3,
    input  logic signed [mfpzs_pkg::VAL_W-1:0]  label,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mfpzs_pkg::ROW_W-1:0]         row,
    output logic [mfpzs_pkg::COL_W-1:0]         col,
    output logic signed [mfpzs_pkg::VAL_W-1:0]  value_0,
    output logic signed [mfpzs_pkg::VAL_W-1:0]  value_1,
    output logic signed [mfpzs_pkg::VAL_W-1:0]  value_2,
    output logic signed [mfpzs_pkg::VAL_W-1:0]  value_3
);

    mfpzs_pkg::feat_vec_t feat;
    mfpzs_pkg::q_wr_t     q_wr;
    mfpzs_pkg::q_rd_t     q_rd;
    mfpzs_pkg::result_t   result;
    logic                 q_full;
    logic                 q_pop;
    logic                 accept;

    // The queue is the only thing that can hold the input back.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign feat[0] = feature_0;
    assign feat[1] = feature_1;
    assign feat[2] = feature_2;
    assign feat[3] = feature_3;

    // Counters, configuration and keep test.
    mfpzs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .frame_start (frame_start),
        .feat        (feat),
        .label       (label),
        .q_wr        (q_wr)
    );

    // Kept pixels wait here so that the two sides stall independently.
    mfpzs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    // Output register with lane masking.
    mfpzs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign row     = result.row;
    assign col     = result.col;
    assign value_0 = result.value[0];
    assign value_1 = result.value[1];
    assign value_2 = result.value[2];
    assign value_3 = result.value[3];

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multi-feature pixel zero-suppression block.
// Depends on mfpzs_pkg and multi_feature_pixel_zero_suppress_top, which brings in mfpzs_front, mfpzs_fifo, mfpzs_back.
// Directed pixels come first, then random frames under changing settings.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfpzs_pkg::*;

    // The watchdog ends the run after this many cycles in which neither
    // channel accepts a request.
    localparam int WATCHDOG_LIMIT = 1000;
    // Idle cycles allowed after the last expected result before the block
    // counts as drained. Kept pixels wait in the queue and then in the output
    // register before they come out.
    localparam int DRAIN_CYCLES = 8;

    // One pixel request as the driver presents it.
    typedef struct packed {
        logic             frame_start;
        feat_vec_t        feat;
        logic [VAL_W-1:0] label;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic   in_valid = 1'b0;
    logic   in_stall;
    pixel_t drive_px = '0;

    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value_0;
    logic signed [VAL_W-1:0] value_1;
    logic signed [VAL_W-1:0] value_2;
    logic signed [VAL_W-1:0] value_3;

    // Pixels waiting to be driven, and kept pixels the block still owes us.
    pixel_t  pixel_stream[$];
    result_t kept_pixels[$];

    // Shadow copy of the configuration registers, updated on every write.
    logic [NUM_ROWS_W-1:0] cfg_num_rows = NUM_ROWS_RST;
    logic [NUM_FEAT_W-1:0] cfg_num_feat = NUM_FEAT_RST;
    logic                  cfg_infill = 1'b0;
    logic [MASK_W-1:0]     cfg_mask = MASK_RST;
    logic [VAL_W-1:0]      cfg_thr[LANES] = '{default: '0};

    // Predicted position of the next pixel.
    int unsigned row_cnt = 0;
    int unsigned col_cnt = 0;

    int  send_idle_pct = 21;
    int  recv_stall_pct = 48;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  phase;
    logic    in_taken = 1'b0;
    result_t want_res;
    feat_vec_t seen_val;

    multi_feature_pixel_zero_suppress_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (drive_px.frame_start),
        .feature_0   (drive_px.feat[0]),
        .feature_1   (drive_px.feat[1]),
        .feature_2   (drive_px.feat[2]),
        .feature_3   (drive_px.feat[3]),
        .label       (drive_px.label),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row         (row),
        .col         (col),
        .value_0     (value_0),
        .value_1     (value_1),
        .value_2     (value_2),
        .value_3     (value_3)
    );

    // 20 ns clock: low half first, then high half.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Row count as the block applies it: zero acts as one, and anything past
    // the row limit is held at the limit.
    function automatic int unsigned rows_in_use();
        if (cfg_num_rows == 0)
            return 1;
        if (cfg_num_rows > MAX_ROWS)
            return MAX_ROWS;
        return cfg_num_rows;
    endfunction

    // Applies the keep test to one accepted pixel, queues the kept pixel if
    // it survives, and advances the row and column counters either way.
    function automatic void zero_suppress(input pixel_t px);
        int unsigned lanes;
        int          i;
        logic        keep;
        result_t     res;
        if (px.frame_start)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        keep = 1'b0;
        if (cfg_infill)
        begin
            // Infill mode looks at lane 0 and the label only.
            lanes = 1;
            keep = ($signed(px.feat[0]) >= $signed(cfg_thr[0])) || ($signed(px.label) > 0);
        end
        else
        begin
            if (cfg_num_feat == 0)
                lanes = 1;
            else if (cfg_num_feat > LANE_LIMIT)
                lanes = LANE_LIMIT;
            else
                lanes = cfg_num_feat;
            for (i = 0; i < lanes; i++)
                if (cfg_mask[i] && ($signed(px.feat[i]) >= $signed(cfg_thr[i])))
                    keep = 1'b1;
        end
        if (keep)
        begin
            res.row = ROW_W'(row_cnt);
            res.col = COL_W'(col_cnt);
            for (i = 0; i < LANES; i++)
                res.value[i] = (i < lanes) ? px.feat[i] : '0;
            kept_pixels = {kept_pixels, res};
        end
        // A row count lowered below the current row wraps on the next pixel.
        row_cnt++;
        if (row_cnt >= rows_in_use())
        begin
            row_cnt = 0;
            if (col_cnt < MAX_COLS - 1)
                col_cnt++;
        end
    endfunction

    // Input side. A request is taken at a rising edge with valid high and
    // stall low; the predictor runs on exactly the pixel that was taken.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            zero_suppress(drive_px);
    end

    // Driver. A pixel is held until its request has been taken; only then
    // may the sender idle or move on to the next pixel. The valid decision
    // never looks at in_stall.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pixel_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drive_px <= pixel_stream.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stalls at random, cycle by cycle.
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    // Monitor. Each result taken is checked field by field against the
    // oldest kept pixel still owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (kept_pixels.size() == 0)
                report_error($sformatf("result with nothing expected: row %0d col %0d",
                                       row, col));
            else
            begin
                want_res = kept_pixels.pop_front();
                seen_val = {value_3, value_2, value_1, value_0};
                if (row !== want_res.row)
                    report_error($sformatf("row got %0d expected %0d", row, want_res.row));
                if (col !== want_res.col)
                    report_error($sformatf("col got %0d expected %0d", col, want_res.col));
                for (int i = 0; i < LANES; i++)
                    if (seen_val[i] !== want_res.value[i])
                        report_error($sformatf("value_%0d got %h expected %h (row %0d col %0d)",
                                               i, seen_val[i], want_res.value[i],
                                               want_res.row, want_res.col));
            end
        end
    end

    // Watchdog: any accepted request on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // One register write; the shadow copy follows once the edge has passed.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_ROWS:     cfg_num_rows = data[NUM_ROWS_W-1:0];
            CFG_NUM_FEATURES: cfg_num_feat = data[NUM_FEAT_W-1:0];
            CFG_INFILL_MODE:  cfg_infill = data[0];
            CFG_REQUIRE_MASK: cfg_mask = data[MASK_W-1:0];
            CFG_THRESHOLD_0:  cfg_thr[0] = data;
            CFG_THRESHOLD_1:  cfg_thr[1] = data;
            CFG_THRESHOLD_2:  cfg_thr[2] = data;
            CFG_THRESHOLD_3:  cfg_thr[3] = data;
            default: ;
        endcase
    endtask

    // Writes every register. The narrow registers get random junk above
    // their width, which the block must ignore.
    task automatic set_config(input int rows, input int feats, input int infill,
                              input int mask, input logic [VAL_W-1:0] t0,
                              input logic [VAL_W-1:0] t1, input logic [VAL_W-1:0] t2,
                              input logic [VAL_W-1:0] t3);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        junk[NUM_ROWS_W-1:0] = NUM_ROWS_W'(rows);
        write_reg(CFG_NUM_ROWS, junk);
        junk = CFG_DATA_W'($urandom);
        junk[NUM_FEAT_W-1:0] = NUM_FEAT_W'(feats);
        write_reg(CFG_NUM_FEATURES, junk);
        junk = CFG_DATA_W'($urandom);
        junk[0] = infill[0];
        write_reg(CFG_INFILL_MODE, junk);
        junk = CFG_DATA_W'($urandom);
        junk[MASK_W-1:0] = MASK_W'(mask);
        write_reg(CFG_REQUIRE_MASK, junk);
        write_reg(CFG_THRESHOLD_0, t0);
        write_reg(CFG_THRESHOLD_1, t1);
        write_reg(CFG_THRESHOLD_2, t2);
        write_reg(CFG_THRESHOLD_3, t3);
    endtask

    // Waits until every pixel has been driven and taken, every kept pixel
    // has come out, and dropped pixels have had time to leave the pipe.
    // This is also where the sender pauses until all results are in.
    task automatic wait_idle();
        while (pixel_stream.size() != 0 || in_valid || kept_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_pixel(input logic fs, input logic [VAL_W-1:0] f0,
                             input logic [VAL_W-1:0] f1, input logic [VAL_W-1:0] f2,
                             input logic [VAL_W-1:0] f3, input logic [VAL_W-1:0] lab);
        pixel_t px;
        px.frame_start = fs;
        px.feat = {f3, f2, f1, f0};
        px.label = lab;
        pixel_stream = {pixel_stream, px};
    endtask

    // Threshold choice: the extremes, zero, small values, or anything.
    function automatic logic [VAL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return VAL_W'($urandom_range(0, 127)) - 16'd64;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Sample value biased toward the compare boundary around level.
    function automatic logic [VAL_W-1:0] pick_sample(input logic [VAL_W-1:0] level);
        case ($urandom_range(0, 7))
            0: return level;
            1: return level - 16'd1;
            2: return level + 16'd1;
            3: return 16'h8000;
            4: return 16'h7FFF;
            5: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic random_config();
        int                 rows;
        logic [VAL_W-1:0]   t0;
        case ($urandom_range(0, 7))
            0: rows = 0;
            1: rows = 1;
            2: rows = $urandom_range(2, 8);
            3: rows = $urandom_range(1, 32);
            4: rows = $urandom_range(MAX_ROWS + 1, 2047);
            5: rows = MAX_ROWS;
            default: rows = $urandom_range(2, 16);
        endcase
        t0 = pick_level();
        // A third of the time software broadcasts one threshold to all lanes.
        if ($urandom_range(0, 2) == 0)
            set_config(rows, $urandom_range(0, 7), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 15), t0, t0, t0, t0);
        else
            set_config(rows, $urandom_range(0, 7), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 15), t0, pick_level(), pick_level(), pick_level());
    endtask

    // Queues n pixels. A walk is one long frame with no restart inside it.
    // Otherwise pixels come in frames of a few columns, mostly opened by
    // frame_start, with a sprinkling of stray frame_start flags as noise.
    task automatic fill_pixels(input int n, input logic walk);
        int     left;
        int     flen;
        int     k;
        int     lim;
        pixel_t px;
        left = n;
        while (left > 0)
        begin
            lim = (rows_in_use() > 16) ? 48 : 3 * rows_in_use();
            flen = walk ? left : $urandom_range(1, lim);
            if (flen > left)
                flen = left;
            for (k = 0; k < flen; k++)
            begin
                if (k == 0)
                    px.frame_start = walk || ($urandom_range(0, 3) != 0);
                else
                    px.frame_start = !walk && ($urandom_range(0, 31) == 0);
                for (int i = 0; i < LANES; i++)
                    px.feat[i] = pick_sample(cfg_thr[i]);
                px.label = pick_sample('0);
                pixel_stream = {pixel_stream, px};
            end
            left -= flen;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one lane, threshold zero, full column height.
        add_pixel(1'b1, 16'h0000, 16'h1234, 16'h8000, 16'h7FFF, 16'h0000);
        add_pixel(1'b0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_pixel(1'b0, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);

        // All four lanes, only lanes 1 and 3 allowed to keep a pixel.
        wait_idle();
        set_config(MAX_ROWS, 4, 0, 4'b1010, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
        add_pixel(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
        add_pixel(1'b0, 16'h7FFF, 16'h7FFE, 16'h7FFF, 16'hFFFF, 16'h0000);
        add_pixel(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);

        // Feature count above the lane limit clamps; zero acts as one lane.
        wait_idle();
        set_config(MAX_ROWS, 7, 0, 4'b0100, 16'h0000, 16'h0000, 16'h0005, 16'h0000);
        add_pixel(1'b1, 16'h8000, 16'h8000, 16'h0005, 16'h8000, 16'h0000);
        add_pixel(1'b0, 16'h7FFF, 16'h7FFF, 16'h0004, 16'h7FFF, 16'h0000);
        wait_idle();
        set_config(MAX_ROWS, 0, 0, 4'b0001, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_pixel(1'b0, 16'h8000, 16'h1111, 16'h2222, 16'h3333, 16'h0000);

        // Infill mode: lane 0 at its threshold or a positive label keeps the
        // pixel; the other lanes read as zero whatever they carry.
        wait_idle();
        set_config(MAX_ROWS, 4, 1, 4'b0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        add_pixel(1'b1, 16'h7FFF, 16'h1111, 16'h2222, 16'h3333, 16'h0000);
        add_pixel(1'b0, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001);
        add_pixel(1'b0, 16'h7FFE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        add_pixel(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        add_pixel(1'b0, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);

        // Row count zero acts as one, so every pixel opens a new column.
        wait_idle();
        set_config(0, 1, 0, 4'b0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b1, 16'h0101, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0202, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // A row count past the limit is held at the limit.
        wait_idle();
        set_config(2047, 1, 0, 4'b0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0303, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Row count lowered under the current row: the next pixel wraps.
        wait_idle();
        set_config(8, 1, 0, 4'b0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        wait_idle();
        set_config(2, 1, 0, 4'b0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_pixel(1'b0, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Random phases: sender-light then receiver-light idling, then none.
        // One phase in the middle walks a full 1024-row column to its wrap.
        for (phase = 0; phase < 20; phase++)
        begin
            wait_idle();
            if (phase == 7)
            begin
                send_idle_pct = 48;
                recv_stall_pct = 21;
            end
            if (phase == 14)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (phase == 10)
            begin
                set_config(MAX_ROWS, 4, 0, 4'b1111, pick_level(), pick_level(),
                           pick_level(), pick_level());
                fill_pixels(MAX_ROWS + 6, 1'b1);
            end
            else
            begin
                random_config();
                fill_pixels($urandom_range(16, 40), 1'b0);
            end
        end

        wait_idle();
        if (kept_pixels.size() != 0)
            report_error($sformatf("%0d kept pixels never came out", kept_pixels.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
